// ===== src/pcsd_pkg.sv =====
package pcsd_pkg;

    localparam int unsigned ARG_COUNT = 6;
    localparam int unsigned ARG_W     = 16;
    localparam int unsigned IDX_W     = 3;

    localparam logic [7:0] LETTER_MOVE    = 8'h6D;
    localparam logic [7:0] LETTER_LINE    = 8'h6C;
    localparam logic [7:0] LETTER_LABEL   = 8'h74;
    localparam logic [7:0] LETTER_ERASE   = 8'h65;
    localparam logic [7:0] LETTER_POINT   = 8'h70;
    localparam logic [7:0] LETTER_CONT    = 8'h6E;
    localparam logic [7:0] LETTER_SPACE   = 8'h73;
    localparam logic [7:0] LETTER_ARC     = 8'h61;
    localparam logic [7:0] LETTER_CIRCLE  = 8'h63;
    localparam logic [7:0] LETTER_LINEMOD = 8'h66;
    localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
    localparam logic [7:0] CHAR_NUL       = 8'h00;

    localparam logic [3:0] KIND_MOVE    = 4'd0;
    localparam logic [3:0] KIND_LINE    = 4'd1;
    localparam logic [3:0] KIND_LABEL   = 4'd2;
    localparam logic [3:0] KIND_ERASE   = 4'd3;
    localparam logic [3:0] KIND_POINT   = 4'd4;
    localparam logic [3:0] KIND_CONT    = 4'd5;
    localparam logic [3:0] KIND_SPACE   = 4'd6;
    localparam logic [3:0] KIND_ARC     = 4'd7;
    localparam logic [3:0] KIND_CIRCLE  = 4'd8;
    localparam logic [3:0] KIND_LINEMOD = 4'd9;
    localparam logic [3:0] KIND_UNKNOWN = 4'd10;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ARGS,
        PH_STR
    } phase_t;

    typedef enum logic [1:0] {
        TOK_ARG,
        TOK_ARG_LAST,
        TOK_TEXT
    } tok_op_t;

    typedef struct packed {
        tok_op_t              op;
        logic [3:0]           kind;
        logic [IDX_W-1:0]     idx;
        logic [IDX_W-1:0]     nargs;
        logic [ARG_W-1:0]     data;
        logic                 last;
    } token_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ===== src/pcsd_in_if.sv =====
interface pcsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface

// ===== src/pcsd_out_if.sv =====
interface pcsd_out_if;
    logic               valid;
    logic               ready;
    logic [3:0]         kind;
    logic signed [15:0] arg_a;
    logic signed [15:0] arg_b;
    logic signed [15:0] arg_c;
    logic signed [15:0] arg_d;
    logic signed [15:0] arg_e;
    logic signed [15:0] arg_f;
    logic [7:0]         text_byte;
    logic               text_last;

    modport source (
        output valid, output kind, output arg_a, output arg_b, output arg_c,
        output arg_d, output arg_e, output arg_f, output text_byte, output text_last,
        input ready
    );
    modport sink (
        input valid, input kind, input arg_a, input arg_b, input arg_c,
        input arg_d, input arg_e, input arg_f, input text_byte, input text_last,
        output ready
    );
endinterface

// ===== src/pcsd_front.sv =====
module pcsd_front (
    input  logic                clk,
    input  logic                rst_n,
    pcsd_in_if.sink             byte_in,
    input  pcsd_pkg::q_status_t q_stat,
    output logic                push,
    output pcsd_pkg::token_t    push_tok
);

    pcsd_pkg::phase_t              phase_reg, phase_next;
    logic [3:0]                    kind_reg, kind_next;
    logic [pcsd_pkg::IDX_W-1:0]    needed_reg, needed_next;
    logic [pcsd_pkg::IDX_W-1:0]    done_reg, done_next;
    logic                          high_reg, high_next;
    logic [7:0]                    low_reg, low_next;
    logic                          accept;
    logic [7:0]                    b;
    logic [pcsd_pkg::IDX_W-1:0]    done_inc;

    assign byte_in.ready = !q_stat.full;
    assign accept        = byte_in.valid && byte_in.ready;
    assign b             = byte_in.stream_byte;
    assign done_inc      = done_reg + 3'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= pcsd_pkg::PH_IDLE;
            kind_reg   <= '0;
            needed_reg <= '0;
            done_reg   <= '0;
            high_reg   <= 1'b0;
            low_reg    <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            kind_reg   <= kind_next;
            needed_reg <= needed_next;
            done_reg   <= done_next;
            high_reg   <= high_next;
            low_reg    <= low_next;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        kind_next   = kind_reg;
        needed_next = needed_reg;
        done_next   = done_reg;
        high_next   = high_reg;
        low_next    = low_reg;
        push        = 1'b0;
        push_tok    = '0;
        push_tok.op = pcsd_pkg::TOK_TEXT;
        if (accept)
        begin
            case (phase_reg)
                pcsd_pkg::PH_ARGS:
                begin
                    if (!high_reg)
                    begin
                        low_next  = b;
                        high_next = 1'b1;
                    end
                    else
                    begin
                        high_next      = 1'b0;
                        done_next      = done_inc;
                        push           = 1'b1;
                        push_tok.kind  = kind_reg;
                        push_tok.idx   = done_reg;
                        push_tok.nargs = needed_reg;
                        push_tok.data  = {b, low_reg};
                        if (done_inc >= needed_reg)
                        begin
                            push_tok.op = pcsd_pkg::TOK_ARG_LAST;
                            phase_next  = pcsd_pkg::PH_IDLE;
                        end
                        else
                        begin
                            push_tok.op = pcsd_pkg::TOK_ARG;
                        end
                    end
                end
                pcsd_pkg::PH_STR:
                begin
                    push          = 1'b1;
                    push_tok.op   = pcsd_pkg::TOK_TEXT;
                    push_tok.kind = kind_reg;
                    if (b == pcsd_pkg::CHAR_NEWLINE || b == pcsd_pkg::CHAR_NUL)
                    begin
                        push_tok.last = 1'b1;
                        phase_next    = pcsd_pkg::PH_IDLE;
                    end
                    else
                    begin
                        push_tok.data = {8'h00, b};
                    end
                end
                default:
                begin
                    done_next = '0;
                    high_next = 1'b0;
                    case (b)
                        pcsd_pkg::LETTER_MOVE:
                        begin
                            kind_next   = pcsd_pkg::KIND_MOVE;
                            needed_next = 3'd2;
                            phase_next  = pcsd_pkg::PH_ARGS;
                        end
                        pcsd_pkg::LETTER_LINE:
                        begin
                            kind_next   = pcsd_pkg::KIND_LINE;
                            needed_next = 3'd4;
                            phase_next  = pcsd_pkg::PH_ARGS;
                        end
                        pcsd_pkg::LETTER_LABEL:
                        begin
                            kind_next   = pcsd_pkg::KIND_LABEL;
                            needed_next = 3'd0;
                            phase_next  = pcsd_pkg::PH_STR;
                        end
                        pcsd_pkg::LETTER_ERASE:
                        begin
                            kind_next     = pcsd_pkg::KIND_ERASE;
                            needed_next   = 3'd0;
                            push          = 1'b1;
                            push_tok.kind = pcsd_pkg::KIND_ERASE;
                        end
                        pcsd_pkg::LETTER_POINT:
                        begin
                            kind_next   = pcsd_pkg::KIND_POINT;
                            needed_next = 3'd2;
                            phase_next  = pcsd_pkg::PH_ARGS;
                        end
                        pcsd_pkg::LETTER_CONT:
                        begin
                            kind_next   = pcsd_pkg::KIND_CONT;
                            needed_next = 3'd2;
                            phase_next  = pcsd_pkg::PH_ARGS;
                        end
                        pcsd_pkg::LETTER_SPACE:
                        begin
                            kind_next   = pcsd_pkg::KIND_SPACE;
                            needed_next = 3'd4;
                            phase_next  = pcsd_pkg::PH_ARGS;
                        end
                        pcsd_pkg::LETTER_ARC:
                        begin
                            kind_next   = pcsd_pkg::KIND_ARC;
                            needed_next = 3'd6;
                            phase_next  = pcsd_pkg::PH_ARGS;
                        end
                        pcsd_pkg::LETTER_CIRCLE:
                        begin
                            kind_next   = pcsd_pkg::KIND_CIRCLE;
                            needed_next = 3'd3;
                            phase_next  = pcsd_pkg::PH_ARGS;
                        end
                        pcsd_pkg::LETTER_LINEMOD:
                        begin
                            kind_next   = pcsd_pkg::KIND_LINEMOD;
                            needed_next = 3'd0;
                            phase_next  = pcsd_pkg::PH_STR;
                        end
                        default:
                        begin
                            done_next     = done_reg;
                            high_next     = high_reg;
                            phase_next    = pcsd_pkg::PH_IDLE;
                            push          = 1'b1;
                            push_tok.kind = pcsd_pkg::KIND_UNKNOWN;
                            push_tok.data = {8'h00, b};
                        end
                    endcase
                end
            endcase
        end
    end

endmodule

// ===== src/pcsd_queue.sv =====
module pcsd_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  pcsd_pkg::token_t     push_tok,
    input  logic                 pop,
    output pcsd_pkg::token_t     head_tok,
    output pcsd_pkg::q_status_t  q_stat
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    pcsd_pkg::token_t   entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head_tok     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_tok;
        end
    end

endmodule

// ===== src/pcsd_back.sv =====
module pcsd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  pcsd_pkg::token_t    head_tok,
    input  pcsd_pkg::q_status_t q_stat,
    output logic                pop,
    pcsd_out_if.source          result_out
);

    logic [pcsd_pkg::ARG_W-1:0] store_reg [pcsd_pkg::ARG_COUNT];
    logic [pcsd_pkg::ARG_W-1:0] arg_sel   [pcsd_pkg::ARG_COUNT];
    logic [pcsd_pkg::ARG_W-1:0] arg_q_reg [pcsd_pkg::ARG_COUNT];
    logic                       valid_reg;
    logic [3:0]                 kind_reg;
    logic [7:0]                 text_byte_reg;
    logic                       text_last_reg;
    logic                       slot_free;
    logic                       emit;

    assign slot_free = !valid_reg || result_out.ready;
    assign pop       = !q_stat.empty && (head_tok.op == pcsd_pkg::TOK_ARG || slot_free);
    assign emit      = pop && head_tok.op != pcsd_pkg::TOK_ARG;

    always_comb
    begin
        for (int i = 0; i < pcsd_pkg::ARG_COUNT; i++)
        begin
            arg_sel[i] = '0;
            if (head_tok.op == pcsd_pkg::TOK_ARG_LAST &&
                pcsd_pkg::IDX_W'(i) < head_tok.nargs)
            begin
                arg_sel[i] = (pcsd_pkg::IDX_W'(i) == head_tok.idx) ? head_tok.data
                                                                   : store_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head_tok.op != pcsd_pkg::TOK_TEXT)
        begin
            for (int i = 0; i < pcsd_pkg::ARG_COUNT; i++)
            begin
                if (pcsd_pkg::IDX_W'(i) == head_tok.idx)
                begin
                    store_reg[i] <= head_tok.data;
                end
            end
        end
        if (emit)
        begin
            kind_reg      <= head_tok.kind;
            text_byte_reg <= (head_tok.op == pcsd_pkg::TOK_TEXT) ? head_tok.data[7:0]
                                                                 : 8'h00;
            text_last_reg <= (head_tok.op == pcsd_pkg::TOK_TEXT) && head_tok.last;
            for (int i = 0; i < pcsd_pkg::ARG_COUNT; i++)
            begin
                arg_q_reg[i] <= arg_sel[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (slot_free)
        begin
            valid_reg <= emit;
        end
    end

    assign result_out.valid     = valid_reg;
    assign result_out.kind      = kind_reg;
    assign result_out.arg_a     = arg_q_reg[0];
    assign result_out.arg_b     = arg_q_reg[1];
    assign result_out.arg_c     = arg_q_reg[2];
    assign result_out.arg_d     = arg_q_reg[3];
    assign result_out.arg_e     = arg_q_reg[4];
    assign result_out.arg_f     = arg_q_reg[5];
    assign result_out.text_byte = text_byte_reg;
    assign result_out.text_last = text_last_reg;

endmodule

// ===== src/plot_command_stream_decoder.sv =====
// Plot command stream decoder.
// byte_in carries one raw byte of the plot command stream per beat; result_out
// carries one decoded result per beat (kind, six arguments, text byte, text_last).
// Both channels use valid/ready; a beat moves when both are high at a clock edge.
// A command letter with arguments gives one result after its last high byte;
// erase and unknown letters give one right away; each label or linemod string
// byte gives one, and newline or zero gives a closing result with text_last.
// A result passes through the token queue and then the output register before
// it is valid. Throughput: one byte per cycle while the queue is not full,
// one result per cycle while result_out is ready; the front decoder, the
// token queue and the output register each take one beat per cycle.
// The queue (QUEUE_DEPTH tokens) parts the decoder from the output stage:
// when result_out stalls, argument bytes still flow until the queue fills,
// then byte_in.ready drops until the receiver takes the held result.
// Reset (rst_n low, asynchronous) returns the decoder to waiting for a command
// letter, empties the queue and drops result_out.valid. No clearing pass.
module plot_command_stream_decoder #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    pcsd_in_if.sink     byte_in,
    pcsd_out_if.source  result_out
);

    logic                 push;
    logic                 pop;
    pcsd_pkg::token_t     push_tok;
    pcsd_pkg::token_t     head_tok;
    pcsd_pkg::q_status_t  q_stat;

    pcsd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .byte_in  (byte_in),
        .q_stat   (q_stat),
        .push     (push),
        .push_tok (push_tok)
    );

    pcsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_tok (push_tok),
        .pop      (pop),
        .head_tok (head_tok),
        .q_stat   (q_stat)
    );

    pcsd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_tok   (head_tok),
        .q_stat     (q_stat),
        .pop        (pop),
        .result_out (result_out)
    );

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("token pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("token popped from an empty queue");

    a_last_only_on_string: assert property (@(posedge clk) disable iff (!rst_n)
        (result_out.valid && result_out.text_last) |->
            (result_out.kind == pcsd_pkg::KIND_LABEL ||
             result_out.kind == pcsd_pkg::KIND_LINEMOD))
        else $error("text_last on a non-string result");

    a_unknown_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (result_out.valid && result_out.kind == pcsd_pkg::KIND_UNKNOWN) |->
            (result_out.arg_a == 16'sd0 && result_out.arg_b == 16'sd0 &&
             result_out.arg_c == 16'sd0 && !result_out.text_last))
        else $error("unknown result carries argument or terminator data");
`endif

endmodule
